@@ hdl/bilinear_texture_sampler_macros.svh @@
// assertion macros shared by the sampler checker
`ifndef BILINEAR_TEXTURE_SAMPLER_MACROS_SVH
`define BILINEAR_TEXTURE_SAMPLER_MACROS_SVH

// implication checked on every clock edge outside reset
`define BTS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// plain invariant checked on every clock edge outside reset
`define BTS_ASSERT_HOLD(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error(msg);

`endif

@@ hdl/bts_pkg.sv @@
// shared types and constants of the bilinear texture sampler
package bts_pkg;

  localparam int unsigned CFG_DATA_W   = 9;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned CHAN_W       = 8;
  localparam int unsigned NUM_CHAN     = 3;
  localparam int unsigned TEXEL_W      = CHAN_W * NUM_CHAN;
  localparam int unsigned OUT_W        = 16;
  localparam int unsigned COORD_W      = 32;
  localparam int unsigned COORD_FRAC_W = 16;
  // wide enough for any size in use, up to the largest store of 4096
  localparam int unsigned DIM_W        = 13;
  localparam int unsigned NUM_BANKS    = 4;
  localparam int unsigned BANK_SEL_W   = 2;

  localparam logic [CFG_IDX_W-1:0]  REG_TEX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0]  REG_TEX_HEIGHT = 1'b1;
  localparam logic [CFG_DATA_W-1:0] TEX_DIM_RESET  = 9'd256;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [OUT_W-1:0] CHAN_OUT_MAX = 16'hFF00;

  typedef struct packed {
    logic                       opcode;
    logic [CHAN_W-1:0]          texel_x;
    logic [CHAN_W-1:0]          texel_y;
    logic [CHAN_W-1:0]          red_in;
    logic [CHAN_W-1:0]          green_in;
    logic [CHAN_W-1:0]          blue_in;
    logic signed [COORD_W-1:0]  coord_u;
    logic signed [COORD_W-1:0]  coord_v;
  } cmd_t;

  typedef struct packed {
    logic [OUT_W-1:0] red_out;
    logic [OUT_W-1:0] green_out;
    logic [OUT_W-1:0] blue_out;
  } result_t;

  // parity of the four neighbour coordinates, picks a bank per tap
  typedef struct packed {
    logic x0_odd;
    logic x1_odd;
    logic y0_odd;
    logic y1_odd;
  } tap_sel_t;

endpackage

@@ hdl/bts_coord.sv @@
// coordinate stage: wrap, scale, clamp and bank address generation
module bts_coord
  import bts_pkg::*;
#(
  parameter int unsigned MAX_WIDTH   = 256,
  parameter int unsigned MAX_HEIGHT  = 256,
  parameter int unsigned WEIGHT_BITS = 8,
  localparam int unsigned XW = $clog2(MAX_WIDTH),
  localparam int unsigned YW = $clog2(MAX_HEIGHT),
  localparam int unsigned XH = (XW > 1) ? XW - 1 : 1,
  localparam int unsigned YH = (YW > 1) ? YW - 1 : 1,
  localparam int unsigned AW = XH + YH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              sample_i,
  input  logic signed [COORD_W-1:0]         coord_u_i,
  input  logic signed [COORD_W-1:0]         coord_v_i,
  input  logic [CFG_DATA_W-1:0]             tex_width_i,
  input  logic [CFG_DATA_W-1:0]             tex_height_i,
  output logic                              rd_valid_o,
  output logic [NUM_BANKS-1:0][AW-1:0]      rd_addr_o,
  output tap_sel_t                          sel_o,
  output logic [WEIGHT_BITS-1:0]            wu_o,
  output logic [WEIGHT_BITS-1:0]            wv_o
);

  localparam int unsigned PW = COORD_FRAC_W + DIM_W;
  localparam logic [DIM_W-1:0] MAX_W_D = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] MAX_H_D = DIM_W'(MAX_HEIGHT);

  function automatic logic [DIM_W-1:0] eff_dim(input logic [CFG_DATA_W-1:0] r,
                                               input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] rx;
    rx = DIM_W'(r);
    if (rx == '0) begin
      return DIM_W'(1);
    end else if (rx > maxv) begin
      return maxv;
    end
    return rx;
  endfunction

  logic [DIM_W-1:0] dim_w, dim_h;
  logic [PW-1:0]    prod_u, prod_v;

  always_comb begin
    dim_w  = eff_dim(tex_width_i, MAX_W_D);
    dim_h  = eff_dim(tex_height_i, MAX_H_D);
    prod_u = PW'(coord_u_i[COORD_FRAC_W-1:0]) * PW'(dim_w);
    prod_v = PW'(coord_v_i[COORD_FRAC_W-1:0]) * PW'(dim_h);
  end

  logic                   v1_q;
  logic [XW-1:0]          x0_q, xl_q;
  logic [YW-1:0]          y0_q, yl_q;
  logic [WEIGHT_BITS-1:0] wu_q, wv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sample_i) begin
      x0_q <= XW'(prod_u[PW-1:COORD_FRAC_W]);
      y0_q <= YW'(prod_v[PW-1:COORD_FRAC_W]);
      wu_q <= prod_u[COORD_FRAC_W-1 -: WEIGHT_BITS];
      wv_q <= prod_v[COORD_FRAC_W-1 -: WEIGHT_BITS];
      xl_q <= XW'(dim_w - DIM_W'(1));
      yl_q <= YW'(dim_h - DIM_W'(1));
    end
  end

  // +1 neighbour, clamped to the last column or row
  logic [XW-1:0] x1;
  logic [YW-1:0] y1;

  assign x1 = (x0_q < xl_q) ? x0_q + XW'(1) : xl_q;
  assign y1 = (y0_q < yl_q) ? y0_q + YW'(1) : yl_q;

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_addr
    localparam logic PX = (b % 2) == 1;
    localparam logic PY = (b / 2) == 1;
    logic [XW-1:0] col;
    logic [YW-1:0] row;
    assign col          = (x0_q[0] == PX) ? x0_q : x1;
    assign row          = (y0_q[0] == PY) ? y0_q : y1;
    assign rd_addr_o[b] = {YH'(row >> 1), XH'(col >> 1)};
  end

  assign sel_o      = '{x0_odd: x0_q[0], x1_odd: x1[0], y0_odd: y0_q[0], y1_odd: y1[0]};
  assign rd_valid_o = v1_q;
  assign wu_o       = wu_q;
  assign wv_o       = wv_q;

endmodule

@@ hdl/bts_texmem.sv @@
// texel store: four parity banks, one write port and one read per bank
module bts_texmem
  import bts_pkg::*;
#(
  parameter int unsigned AW = 14
) (
  input  logic                                clk_i,
  input  logic                                wr_en_i,
  input  logic [BANK_SEL_W-1:0]               wr_bank_i,
  input  logic [AW-1:0]                       wr_addr_i,
  input  logic [TEXEL_W-1:0]                  wr_data_i,
  input  logic                                rd_en_i,
  input  logic [NUM_BANKS-1:0][AW-1:0]        rd_addr_i,
  output logic [NUM_BANKS-1:0][TEXEL_W-1:0]   rd_data_o
);

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    logic [TEXEL_W-1:0] mem_q [2**AW];
    logic [TEXEL_W-1:0] rd_q;

    // read returns the old word when a write hits the same entry
    always_ff @(posedge clk_i) begin
      if (wr_en_i && (wr_bank_i == BANK_SEL_W'(b))) begin
        mem_q[wr_addr_i] <= wr_data_i;
      end
      if (rd_en_i) begin
        rd_q <= mem_q[rd_addr_i[b]];
      end
    end

    assign rd_data_o[b] = rd_q;
  end

endmodule

@@ hdl/bts_blend.sv @@
// blend pipeline: corner weights, per-tap products and channel sums
module bts_blend
  import bts_pkg::*;
#(
  parameter int unsigned WEIGHT_BITS = 8
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  logic [WEIGHT_BITS-1:0]             wu_i,
  input  logic [WEIGHT_BITS-1:0]             wv_i,
  input  tap_sel_t                           sel_i,
  input  logic [NUM_BANKS-1:0][TEXEL_W-1:0]  rd_data_i,
  output logic                               valid_o,
  output result_t                            result_o
);

  localparam int unsigned FW    = WEIGHT_BITS + 1;
  localparam int unsigned KW    = 2 * WEIGHT_BITS + 1;
  localparam int unsigned PW    = 2 * WEIGHT_BITS + CHAN_W;
  localparam int unsigned SHIFT = 2 * WEIGHT_BITS - CHAN_W;

  // tap order: 0 top-left, 1 top-right, 2 bottom-left, 3 bottom-right
  logic [FW-1:0]                 full, iu, iv, wu_x, wv_x;
  logic [NUM_BANKS-1:0][KW-1:0]  k_d;

  always_comb begin
    full   = FW'(1) << WEIGHT_BITS;
    wu_x   = FW'(wu_i);
    wv_x   = FW'(wv_i);
    iu     = full - wu_x;
    iv     = full - wv_x;
    k_d[0] = KW'(iu) * KW'(iv);
    k_d[1] = KW'(wu_x) * KW'(iv);
    k_d[2] = KW'(iu) * KW'(wv_x);
    k_d[3] = KW'(wu_x) * KW'(wv_x);
  end

  logic                          v2_q, v3_q, v4_q;
  tap_sel_t                      sel2_q;
  logic [NUM_BANKS-1:0][KW-1:0]  k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v2_q <= valid_i;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sel2_q <= sel_i;
    k_q    <= k_d;
  end

  // pick each corner out of its bank
  logic [NUM_BANKS-1:0][TEXEL_W-1:0]        tap;
  logic [NUM_CHAN-1:0][NUM_BANKS-1:0][PW-1:0] prod_d, prod_q;

  always_comb begin
    tap[0] = rd_data_i[{sel2_q.y0_odd, sel2_q.x0_odd}];
    tap[1] = rd_data_i[{sel2_q.y0_odd, sel2_q.x1_odd}];
    tap[2] = rd_data_i[{sel2_q.y1_odd, sel2_q.x0_odd}];
    tap[3] = rd_data_i[{sel2_q.y1_odd, sel2_q.x1_odd}];
    for (int c = 0; c < NUM_CHAN; c++) begin
      for (int t = 0; t < NUM_BANKS; t++) begin
        prod_d[c][t] = PW'(tap[t][c*CHAN_W +: CHAN_W]) * PW'(k_q[t]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  // weights add up to full scale, so the sum never overflows
  logic [NUM_CHAN-1:0][PW-1:0]    sum;
  logic [NUM_CHAN-1:0][OUT_W-1:0] res_q;

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      sum[c] = prod_q[c][0] + prod_q[c][1] + prod_q[c][2] + prod_q[c][3];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      res_q[c] <= sum[c][SHIFT +: OUT_W];
    end
  end

  assign valid_o            = v4_q;
  assign result_o.red_out   = res_q[0];
  assign result_o.green_out = res_q[1];
  assign result_o.blue_out  = res_q[2];

endmodule

@@ hdl/bilinear_texture_sampler.sv @@
// top level of the bilinear texture sampler with repeat wrap
//
// usage:
// - configuration: cfg_we_i writes cfg_data_i into the register picked by
//   cfg_idx_i (texture width, texture height) at the clock edge; the user must
//   write only while no sample is in flight, which the block does not enforce
// - command channel: a word on cmd_i is taken at each edge with start_i high
//   and busy_o low; busy_o stays low, so one word per cycle is taken
// - a texel write word stores its texel at the accepting edge and gives no
//   result; a sample issued in the next cycle already sees it
// - a sample word gives one result word, shown on result_o with result_valid_o
//   high for one cycle after the coordinate, bank read, product and result registers
// - results come in command order, one per cycle at full rate; the receiver
//   cannot stall, so nothing holds back the pipeline
// - the four neighbour texels come from four parity banks at once, so
//   the rate is set by the single read port of each bank: one sample a cycle
// - reset clears the pipeline and sets both sizes to 256; texture contents
//   are undefined until written and get no clearing pass
module bilinear_texture_sampler
  import bts_pkg::*;
#(
  parameter int unsigned MAX_WIDTH   = 256,
  parameter int unsigned MAX_HEIGHT  = 256,
  parameter int unsigned WEIGHT_BITS = 8
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   start_i,
  input  cmd_t                   cmd_i,
  output logic                   busy_o,
  output logic                   result_valid_o,
  output result_t                result_o
);

  localparam int unsigned XW = $clog2(MAX_WIDTH);
  localparam int unsigned YW = $clog2(MAX_HEIGHT);
  localparam int unsigned XH = (XW > 1) ? XW - 1 : 1;
  localparam int unsigned YH = (YW > 1) ? YW - 1 : 1;
  localparam int unsigned AW = XH + YH;

  // size registers
  logic [CFG_DATA_W-1:0] tex_width_q, tex_height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tex_width_q  <= TEX_DIM_RESET;
      tex_height_q <= TEX_DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TEX_WIDTH:  tex_width_q  <= cfg_data_i;
        REG_TEX_HEIGHT: tex_height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // fully pipelined, never refuses a word
  assign busy_o = 1'b0;

  logic accept, sample_acc, write_acc, in_store;

  assign accept     = start_i && !busy_o;
  assign sample_acc = accept && (cmd_i.opcode == OP_SAMPLE);
  // writes outside the store are dropped
  assign in_store   = (DIM_W'(cmd_i.texel_x) < DIM_W'(MAX_WIDTH)) &&
                      (DIM_W'(cmd_i.texel_y) < DIM_W'(MAX_HEIGHT));
  assign write_acc  = accept && (cmd_i.opcode == OP_WRITE) && in_store;

  // texel write goes straight to its parity bank at the accepting edge;
  // older samples still in flight read the old word on a same-edge collision
  logic [XW-1:0]         wr_x;
  logic [YW-1:0]         wr_y;
  logic [BANK_SEL_W-1:0] wr_bank;
  logic [AW-1:0]         wr_addr;
  logic [TEXEL_W-1:0]    wr_data;

  assign wr_x    = XW'(cmd_i.texel_x);
  assign wr_y    = YW'(cmd_i.texel_y);
  assign wr_bank = {wr_y[0], wr_x[0]};
  assign wr_addr = {YH'(wr_y >> 1), XH'(wr_x >> 1)};
  assign wr_data = {cmd_i.blue_in, cmd_i.green_in, cmd_i.red_in};

  // sample path
  logic                               rd_valid;
  logic [NUM_BANKS-1:0][AW-1:0]       rd_addr;
  logic [NUM_BANKS-1:0][TEXEL_W-1:0]  rd_data;
  tap_sel_t                           tap_sel;
  logic [WEIGHT_BITS-1:0]             wu, wv;

  bts_coord #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_HEIGHT  (MAX_HEIGHT),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_coord (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .sample_i     (sample_acc),
    .coord_u_i    (cmd_i.coord_u),
    .coord_v_i    (cmd_i.coord_v),
    .tex_width_i  (tex_width_q),
    .tex_height_i (tex_height_q),
    .rd_valid_o   (rd_valid),
    .rd_addr_o    (rd_addr),
    .sel_o        (tap_sel),
    .wu_o         (wu),
    .wv_o         (wv)
  );

  bts_texmem #(
    .AW (AW)
  ) u_texmem (
    .clk_i     (clk_i),
    .wr_en_i   (write_acc),
    .wr_bank_i (wr_bank),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_valid),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  bts_blend #(
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_blend (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (rd_valid),
    .wu_i      (wu),
    .wv_i      (wv),
    .sel_i     (tap_sel),
    .rd_data_i (rd_data),
    .valid_o   (result_valid_o),
    .result_o  (result_o)
  );

endmodule

@@ hdl/bts_checker.sv @@
// port-level checker for the sampler and its bind
`include "bilinear_texture_sampler_macros.svh"

module bts_checker
  import bts_pkg::*;
(
  input logic    clk_i,
  input logic    rst_ni,
  input logic    start_i,
  input cmd_t    cmd_i,
  input logic    busy_o,
  input logic    result_valid_o,
  input result_t result_o
);

  logic sample_acc, write_acc, chan_ok;

  assign sample_acc = start_i && !busy_o && (cmd_i.opcode == OP_SAMPLE);
  assign write_acc  = start_i && !busy_o && (cmd_i.opcode == OP_WRITE);
  assign chan_ok    = (result_o.red_out <= CHAN_OUT_MAX) &&
                      (result_o.green_out <= CHAN_OUT_MAX) &&
                      (result_o.blue_out <= CHAN_OUT_MAX);

  // every sample word comes back as a result word, and every result word stems from a sample
  `BTS_ASSERT_IMP(a_sample_latency, sample_acc, ##4 result_valid_o, "sample word lost or late")
  `BTS_ASSERT_IMP(a_result_origin, result_valid_o, $past(sample_acc, 4), "result without a sample")
  `BTS_ASSERT_IMP(a_write_silent, write_acc, ##4 !result_valid_o, "texel write gave a result word")
  `BTS_ASSERT_HOLD(a_chan_range, !result_valid_o || chan_ok, "blended channel above full scale")

endmodule

bind bilinear_texture_sampler bts_checker u_checker (.*);

@@ test/bilinear_texture_sampler_tb.sv @@
// self-checking testbench of the bilinear texture sampler: texel writes, samples, size settings
`timescale 1ns / 1ps

module bilinear_texture_sampler_tb;
  import bts_pkg::*;

  // geometry of the block under test, kept at its defaults
  localparam int unsigned TEX_MAX_W   = 256;
  localparam int unsigned TEX_MAX_H   = 256;
  localparam int unsigned WEIGHT_BITS = 8;
  localparam int unsigned FULL_WEIGHT = 1 << WEIGHT_BITS;

  // how long a sample word takes to come back after it was taken
  localparam int unsigned RESULT_LATENCY = 4;
  localparam int unsigned SETTLE_CYCLES  = RESULT_LATENCY + 4;

  // watchdog bound on the length of a run
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  logic                  clk_i;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = REG_TEX_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  start_i    = 1'b0;
  cmd_t                  cmd_i      = '0;
  logic                  busy_o;
  logic                  result_valid_o;
  result_t               result_o;

  bilinear_texture_sampler #(
    .MAX_WIDTH  (TEX_MAX_W),
    .MAX_HEIGHT (TEX_MAX_H),
    .WEIGHT_BITS(WEIGHT_BITS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .start_i       (start_i),
    .cmd_i         (cmd_i),
    .busy_o        (busy_o),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  // own copy of the block state: texture, which texels hold data, sizes
  logic [TEXEL_W-1:0] texel_mem [TEX_MAX_W*TEX_MAX_H];
  bit                 texel_seen [TEX_MAX_W*TEX_MAX_H];
  logic [CFG_DATA_W-1:0] size_w_reg = TEX_DIM_RESET;
  logic [CFG_DATA_W-1:0] size_h_reg = TEX_DIM_RESET;

  // blended colors still owed by the block, oldest first
  result_t     blend_expected [$];
  result_t     next_blend;
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt    = 0;
  // chance in percent that the sender leaves a cycle empty
  int unsigned idle_pct     = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // watchdog: a hung handshake or a lost result ends here
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // size register as the block uses it: zero acts as 1, too large saturates
  function automatic int unsigned size_in_use(logic [CFG_DATA_W-1:0] r, int unsigned max_v);
    int unsigned rv;
    rv = 32'(r);
    if (rv == 0) return 1;
    if (rv > max_v) return max_v;
    return rv;
  endfunction

  // fraction of a Q16.16 coordinate scaled by the size: texel index and weight
  function automatic void split_coord(input logic [COORD_W-1:0] c, input int unsigned size,
                                      output int unsigned idx, output int unsigned wt);
    int unsigned p;
    p   = int'(c[COORD_FRAC_W-1:0]) * size;
    idx = p >> COORD_FRAC_W;
    wt  = (p & 32'hFFFF) >> (COORD_FRAC_W - WEIGHT_BITS);
  endfunction

  // the four neighbours of a sample, +1 neighbour clamped to the last column/row
  function automatic void neighbour_taps(input cmd_t c,
                                         output int unsigned x0, output int unsigned x1,
                                         output int unsigned y0, output int unsigned y1,
                                         output int unsigned wu, output int unsigned wv);
    int unsigned w;
    int unsigned h;
    w = size_in_use(size_w_reg, TEX_MAX_W);
    h = size_in_use(size_h_reg, TEX_MAX_H);
    split_coord(c.coord_u, w, x0, wu);
    split_coord(c.coord_v, h, y0, wv);
    x1 = (x0 + 1 < w) ? x0 + 1 : w - 1;
    y1 = (y0 + 1 < h) ? y0 + 1 : h - 1;
  endfunction

  function automatic result_t predict_blend(cmd_t c);
    int unsigned x0, x1, y0, y1, wu, wv;
    logic [TEXEL_W-1:0] t00, t10, t01, t11;
    longint unsigned k00, k10, k01, k11, acc;
    logic [OUT_W-1:0] chan [NUM_CHAN];
    result_t r;
    neighbour_taps(c, x0, x1, y0, y1, wu, wv);
    t00 = texel_mem[y0*TEX_MAX_W + x0];
    t10 = texel_mem[y0*TEX_MAX_W + x1];
    t01 = texel_mem[y1*TEX_MAX_W + x0];
    t11 = texel_mem[y1*TEX_MAX_W + x1];
    k00 = longint'(FULL_WEIGHT - wu) * (FULL_WEIGHT - wv);
    k10 = longint'(wu) * (FULL_WEIGHT - wv);
    k01 = longint'(FULL_WEIGHT - wu) * wv;
    k11 = longint'(wu) * wv;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      acc = t00[ch*CHAN_W +: CHAN_W] * k00 + t10[ch*CHAN_W +: CHAN_W] * k10
          + t01[ch*CHAN_W +: CHAN_W] * k01 + t11[ch*CHAN_W +: CHAN_W] * k11;
      chan[ch] = OUT_W'(acc >> (2*WEIGHT_BITS - 8));
    end
    // channel 0 is red, 1 green, 2 blue in the texel layout
    r.red_out   = chan[0];
    r.green_out = chan[1];
    r.blue_out  = chan[2];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker: every strobed word is matched against the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (blend_expected.size() == 0) begin
        $error("result word with no sample outstanding: %h", result_o);
        mismatch_cnt++;
      end else begin
        next_blend = blend_expected.pop_front();
        if (result_o.red_out !== next_blend.red_out) begin
          $error("red_out: expected %0d, got %0d", next_blend.red_out, result_o.red_out);
          mismatch_cnt++;
        end
        if (result_o.green_out !== next_blend.green_out) begin
          $error("green_out: expected %0d, got %0d", next_blend.green_out, result_o.green_out);
          mismatch_cnt++;
        end
        if (result_o.blue_out !== next_blend.blue_out) begin
          $error("blue_out: expected %0d, got %0d", next_blend.blue_out, result_o.blue_out);
          mismatch_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // a command word with every field random; callers overwrite what matters
  function automatic cmd_t random_word(logic op);
    cmd_t c;
    c.opcode   = op;
    c.texel_x  = CHAN_W'($urandom);
    c.texel_y  = CHAN_W'($urandom);
    c.red_in   = CHAN_W'($urandom);
    c.green_in = CHAN_W'($urandom);
    c.blue_in  = CHAN_W'($urandom);
    c.coord_u  = $urandom;
    c.coord_v  = $urandom;
    return c;
  endfunction

  // present one word, wait for it to be taken, update the model at that edge
  task automatic send_word(cmd_t c);
    int unsigned addr;
    start_i <= 1'b1;
    cmd_i   <= c;
    do @(posedge clk_i); while (busy_o);
    if (c.opcode == OP_WRITE) begin
      // the whole 8-bit range lies inside the store, so no write is dropped
      addr = int'(c.texel_y) * TEX_MAX_W + int'(c.texel_x);
      texel_mem[addr]  = {c.blue_in, c.green_in, c.red_in};
      texel_seen[addr] = 1'b1;
    end else begin
      blend_expected.push_back(predict_blend(c));
    end
    // random gap after the word; start_i stays high when there is none
    if ($urandom_range(99) < idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task automatic write_texel(int unsigned x, int unsigned y,
                             logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                             logic [CHAN_W-1:0] b);
    cmd_t c;
    c = random_word(OP_WRITE);
    c.texel_x  = CHAN_W'(x);
    c.texel_y  = CHAN_W'(y);
    c.red_in   = r;
    c.green_in = g;
    c.blue_in  = b;
    send_word(c);
  endtask

  // texels that were never written must not be read: give them data first
  task automatic fill_if_empty(int unsigned x, int unsigned y);
    if (!texel_seen[y*TEX_MAX_W + x]) begin
      write_texel(x, y, CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
    end
  endtask

  task automatic sample_at(logic [COORD_W-1:0] u, logic [COORD_W-1:0] v);
    cmd_t c;
    int unsigned x0, x1, y0, y1, wu, wv;
    c = random_word(OP_SAMPLE);
    c.coord_u = u;
    c.coord_v = v;
    neighbour_taps(c, x0, x1, y0, y1, wu, wv);
    fill_if_empty(x0, y0);
    fill_if_empty(x1, y0);
    fill_if_empty(x0, y1);
    fill_if_empty(x1, y1);
    send_word(c);
  endtask

  // stop sending, let every owed result arrive and the pipe run empty
  task automatic drain;
    start_i <= 1'b0;
    while (blend_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // both size registers, written back to back while the block is idle
  task automatic set_size(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_TEX_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    size_w_reg  = w;
    cfg_idx_i  <= REG_TEX_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    size_h_reg  = h;
    cfg_we_i   <= 1'b0;
    cfg_data_i <= '0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset sizes: corner texels, extreme colors, clamped and half-way taps
  task automatic test_edge_taps;
    idle_pct = 37;
    write_texel(0, 0, 8'hFF, 8'hFF, 8'hFF);
    write_texel(1, 0, 8'h00, 8'h00, 8'h00);
    write_texel(0, 1, 8'hFF, 8'h00, 8'hFF);
    write_texel(1, 1, 8'h00, 8'hFF, 8'h00);
    write_texel(255, 255, 8'hFF, 8'hFF, 8'hFF);
    sample_at(32'h0000_0000, 32'h0000_0000);
    // all-ones fraction lands on the last column and row, +1 is clamped
    sample_at(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // most negative coordinate has fraction zero, most positive all ones
    sample_at(32'h8000_0000, 32'h7FFF_FFFF);
    // half-texel and near-full weights between the four corner texels
    sample_at(32'h0000_0080, 32'h0000_0080);
    sample_at(32'h0000_00FF, 32'h0000_00FF);
    drain();
  endtask

  // a sample right behind a write of the same texel must see the new data
  task automatic test_write_then_sample;
    idle_pct = 0;
    write_texel(5, 7, 8'hFF, 8'h00, 8'hAA);
    fill_if_empty(6, 7);
    fill_if_empty(5, 8);
    fill_if_empty(6, 8);
    sample_at(32'h0000_0500, 32'h0000_0700);
    write_texel(5, 7, 8'h12, 8'h34, 8'h56);
    sample_at(32'h0000_0500, 32'h0000_0700);
    // back-to-back samples at full rate
    sample_at(32'h0000_0540, 32'h0000_07C0);
    drain();
  endtask

  // size registers at zero, saturating values and the single-row/column sizes
  task automatic test_size_extremes;
    idle_pct = 0;
    set_size(9'd0, 9'd0);
    sample_at($urandom, $urandom);
    set_size(9'd511, 9'd300);
    sample_at(32'hFFFF_FFFF, 32'h0001_FFFF);
    set_size(9'd1, 9'd256);
    sample_at($urandom, $urandom);
    set_size(9'd256, 9'd1);
    sample_at($urandom, $urandom);
    set_size(9'd2, 9'd2);
    sample_at(32'h0000_FFFF, 32'h0000_7FFF);
    sample_at(32'hFFFF_8000, 32'h0000_0000);
    drain();
  endtask

  // random mix of texel writes and samples over several sizes and idle rates
  task automatic test_random_traffic;
    int unsigned phase_idle [4] = '{0, 77, 0, 37};
    logic [CFG_DATA_W-1:0] slot_w [8] = '{9'd256, 9'd1, 9'd0, 9'd7,
                                          9'd2, 9'd256, 9'd13, 9'd300};
    logic [CFG_DATA_W-1:0] slot_h [8] = '{9'd256, 9'd1, 9'd511, 9'd3,
                                          9'd256, 9'd2, 9'd29, 9'd5};
    int unsigned w, h, pick;
    logic [COORD_W-1:0] u, v;
    for (int p = 0; p < 4; p++) begin
      for (int s = 2*p; s < 2*p + 2; s++) begin
        set_size(slot_w[s], slot_h[s]);
        idle_pct = phase_idle[p];
        w = size_in_use(slot_w[s], TEX_MAX_W);
        h = size_in_use(slot_h[s], TEX_MAX_H);
        // samples also pull in writes for unwritten neighbours
        for (int n = 0; n < 40; n++) begin
          pick = $urandom_range(99);
          if (pick < 35) begin
            // writes inside the region in use, so samples see fresh data
            write_texel($urandom_range(w-1), $urandom_range(h-1),
                        CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
          end else if (pick < 45) begin
            write_texel($urandom_range(255), $urandom_range(255),
                        CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom));
          end else if (pick < 60) begin
            // fractions at zero or all ones, integer part random
            u = $urandom;
            v = $urandom;
            u[COORD_FRAC_W-1:0] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            v[COORD_FRAC_W-1:0] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
            sample_at(u, v);
          end else begin
            sample_at($urandom, $urandom);
          end
        end
      end
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_edge_taps();
    test_write_then_sample();
    test_size_extremes();
    test_random_traffic();
    // leave the registers back at their reset value at the end
    set_size(TEX_DIM_RESET, TEX_DIM_RESET);
    drain();

    if (mismatch_cnt == 0 && blend_expected.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
